[src/rep_pkg.sv]
// rep_pkg: shared types, codes and decoder state tables for the rotary encoder
// position counter
// no dependencies
`default_nettype none

package rep_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int LIMIT_W            = 32;
  localparam int DIR_W              = 2;
  localparam int CFG_INDEX_W        = 2;
  localparam int STATE_W            = 3;
  localparam int ENTRY_W            = 5;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

  // item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_MIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_MAX = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLLOVER  = 2'd3;

  // table entry: emit code in [4:3], next state in [2:0]
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam logic [1:0] EMIT_NONE = 2'b00;
  localparam logic [1:0] EMIT_CW   = 2'b01;
  localparam logic [1:0] EMIT_CCW  = 2'b10;

  localparam entry_t E_CW  = {EMIT_CW, 3'd0};
  localparam entry_t E_CCW = {EMIT_CCW, 3'd0};

  // full step table, column is {pin_b, pin_a}; unused row 7 falls back to start
  localparam entry_t FULL_TAB [0:7][0:3] = '{
    '{5'd0, 5'd2, 5'd4, 5'd0},
    '{5'd3, 5'd0, 5'd1, E_CW},
    '{5'd3, 5'd2, 5'd0, 5'd0},
    '{5'd3, 5'd2, 5'd1, 5'd0},
    '{5'd6, 5'd0, 5'd4, 5'd0},
    '{5'd6, 5'd5, 5'd0, E_CCW},
    '{5'd6, 5'd5, 5'd4, 5'd0},
    '{5'd0, 5'd2, 5'd4, 5'd0}
  };

  // half step table; unused rows 6 and 7 fall back to start
  localparam entry_t HALF_TAB [0:7][0:3] = '{
    '{5'd3,         5'd2, 5'd1, 5'd0},
    '{E_CCW | 5'd3, 5'd0, 5'd1, 5'd0},
    '{E_CW | 5'd3,  5'd2, 5'd0, 5'd0},
    '{5'd3,         5'd5, 5'd4, 5'd0},
    '{5'd3,         5'd3, 5'd4, E_CW},
    '{5'd3,         5'd5, 5'd3, E_CCW},
    '{5'd3,         5'd2, 5'd1, 5'd0},
    '{5'd3,         5'd2, 5'd1, 5'd0}
  };

endpackage

`default_nettype wire

[src/rotary_encoder_position_counter.sv]
// rotary_encoder_position_counter: encoder state table decoder and limited
// position counter, one item in and one item out per cycle while out_stall does not hold a result
// depends on rep_pkg
//
//   channel   handshake              payload
//   -------   --------------------   -----------------------------------
//   in        in_valid / in_stall    func, pin_a, pin_b, load_value
//   out       out_valid / out_stall  direction, moved, position
//   cfg       cfg_we                 cfg_index, cfg_data
//
// table lookup and the step/clamp logic sit between the decoder/position
// registers and the output register, so a new item can be taken every clock
// while the previous result is being taken
// in_stall is raised only while a result waits in the output register and
// out_stall holds it
// rst (synchronous) returns the decoder to its start state, the position to
// zero and the registers to half mode off, limits=0, rollover=1
`default_nettype none

module rotary_encoder_position_counter #(
  parameter int POSITION_WIDTH = rep_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [rep_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rep_pkg::LIMIT_W-1:0]         cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic                                pin_a,
  input  logic                                pin_b,
  input  logic signed [rep_pkg::LIMIT_W-1:0]  load_value,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rep_pkg::DIR_W-1:0]           direction,
  output logic                                moved,
  output logic signed [rep_pkg::LIMIT_W-1:0]  position
);

  import rep_pkg::*;

  // compare width: wide enough for both the position and the 32-bit limits
  localparam int CMP_W = (POSITION_WIDTH > LIMIT_W) ? POSITION_WIDTH : LIMIT_W;

  // configuration registers
  logic                      half_mode;
  logic signed [LIMIT_W-1:0] limit_min;
  logic signed [LIMIT_W-1:0] limit_max;
  logic                      rollover;

  // running state
  logic [STATE_W-1:0]               dec_state;
  logic [STATE_W-1:0]               dec_state_next;
  logic signed [POSITION_WIDTH-1:0] position_count;
  logic signed [POSITION_WIDTH-1:0] position_count_next;

  logic in_accept;
  logic out_load;

  // table lookup
  logic [1:0] col;
  entry_t     entry;
  logic       step_cw;
  logic       step_ccw;

  // limit handling
  logic                             limits_on;
  logic signed [CMP_W-1:0]          min_x;
  logic signed [CMP_W-1:0]          max_x;
  logic signed [POSITION_WIDTH-1:0] pos_step;
  logic signed [CMP_W-1:0]          step_x;
  logic signed [CMP_W-1:0]          load_x;
  logic signed [CMP_W-1:0]          pos_next_x;
  logic [DIR_W-1:0]                 direction_next;
  logic                             moved_next;

  // handshake: take a new item unless a result is stuck in the output register
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = in_accept;

  // decoder: column is {pin_b, pin_a}
  assign col      = {pin_b, pin_a};
  assign entry    = half_mode ? HALF_TAB[dec_state][col] : FULL_TAB[dec_state][col];
  assign step_cw  = (func == FUNC_SAMPLE) && (entry[4:3] == EMIT_CW);
  assign step_ccw = (func == FUNC_SAMPLE) && (entry[4:3] == EMIT_CCW);

  // limits only count when min is strictly below max
  assign limits_on = limit_min < limit_max;
  assign min_x     = CMP_W'(limit_min);
  assign max_x     = CMP_W'(limit_max);
  assign load_x    = CMP_W'(load_value);

  // one step up or down, wrapping in the position width
  assign pos_step = step_cw ? position_count + POSITION_WIDTH'(1)
                            : position_count - POSITION_WIDTH'(1);
  assign step_x   = CMP_W'(pos_step);

  always_comb begin
    dec_state_next      = dec_state;
    position_count_next = position_count;
    direction_next      = DIR_IDLE;
    moved_next          = 1'b0;
    if (func == FUNC_LOAD) begin
      // load: decoder untouched, value wrapped or clamped into range
      position_count_next = POSITION_WIDTH'(load_x);
      if (limits_on && (load_x < min_x)) begin
        position_count_next = rollover ? POSITION_WIDTH'(max_x) : POSITION_WIDTH'(min_x);
      end else if (limits_on && (load_x > max_x)) begin
        position_count_next = rollover ? POSITION_WIDTH'(min_x) : POSITION_WIDTH'(max_x);
      end
    end else begin
      dec_state_next = entry[STATE_W-1:0];
      if (step_cw || step_ccw) begin
        direction_next      = step_cw ? DIR_CW : DIR_CCW;
        moved_next          = 1'b1;
        position_count_next = pos_step;
        // leaving the range: wrap to the other limit or clamp at this one
        if (limits_on && step_cw && (step_x > max_x)) begin
          position_count_next = rollover ? POSITION_WIDTH'(min_x) : POSITION_WIDTH'(max_x);
          moved_next          = rollover;
        end else if (limits_on && step_ccw && (step_x < min_x)) begin
          position_count_next = rollover ? POSITION_WIDTH'(max_x) : POSITION_WIDTH'(min_x);
          moved_next          = rollover;
        end
      end
    end
  end

  // reported position is the low 32 bits of the sign-extended count
  assign pos_next_x = CMP_W'(position_count_next);

  // configuration and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      half_mode      <= 1'b0;
      limit_min      <= '0;
      limit_max      <= '0;
      rollover       <= 1'b1;
      dec_state      <= '0;
      position_count <= '0;
    end else begin
      // a half mode write restarts the decoder
      if (cfg_we && (cfg_index == REG_HALF_MODE)) begin
        dec_state <= '0;
      end else if (in_accept) begin
        dec_state <= dec_state_next;
      end
      if (in_accept) begin
        position_count <= position_count_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF_MODE: half_mode <= cfg_data[0];
          REG_LIMIT_MIN: limit_min <= cfg_data;
          REG_LIMIT_MAX: limit_max <= cfg_data;
          REG_ROLLOVER:  rollover  <= cfg_data[0];
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      direction <= direction_next;
      moved     <= moved_next;
      position  <= pos_next_x[LIMIT_W-1:0];
    end
  end

  // a moved result always carries a direction
  a_moved_has_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && moved |-> direction != DIR_IDLE)
    else $error("moved without direction");

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // a load item never reports a step
  a_load_no_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && (func == FUNC_LOAD) |=> out_valid && (direction == DIR_IDLE) && !moved)
    else $error("load item reported a step");

  // writing the half mode register returns the decoder to its start state
  a_half_mode_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_HALF_MODE) |=> dec_state == '0)
    else $error("decoder not restarted on half mode write");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
